/* design/gsbp_pkg.sv */
// Shared types and constants for the gselect branch predictor.
// No dependencies; the top level references it by scoped names.
`default_nettype none

package gsbp_pkg;

    // Command codes carried in s_tuser
    typedef enum logic [2:0] {
        CMD_LOOKUP  = 3'd0,
        CMD_UPDATE  = 3'd1,
        CMD_SQUASH  = 3'd2,
        CMD_UNCOND  = 3'd3,
        CMD_BTB_MISS = 3'd4
    } cmd_t;

    // Controller states, one-hot
    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    // Fixed field widths of the stream payload
    localparam int TID_W   = 2;
    localparam int ADDR_W  = 64;
    localparam int SHIST_W = 6;
    localparam int SIDX_W  = 12;

endpackage

`default_nettype wire

/* design/gsbp_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Used for the counter table; no package dependency.
`default_nettype none

module gsbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                   aclk,
    input  wire logic                   we,
    input  wire logic [AW-1:0]          waddr,
    input  wire logic [WIDTH-1:0]       wdata,
    input  wire logic                   re,
    input  wire logic [AW-1:0]          raddr,
    output logic      [WIDTH-1:0]       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* design/gselect_branch_predictor.sv */
// Top level of the gselect branch predictor: per-thread history registers,
// counter table in gsbp_ram, stream ports. Depends on gsbp_pkg and gsbp_ram.
`default_nettype none

// Gselect predictor with one global history register per thread and a table of
// saturating counters indexed by {history, word address bits}. Each input
// transaction is accepted in ST_IDLE, which issues the counter table read; then
// ST_EXEC, held while the output register is full and m_tready is low, does the
// read-modify-write of the counter and the history update and loads the output
// register, and only then is a new transaction accepted. Every transaction
// (lookup, update, squash, unconditional branch, target-buffer miss) returns
// exactly one result; non-lookup results are zero. After reset the table is
// cleared one entry per cycle, 2^IB entries (4096 by default), with s_tready low.
module gselect_branch_predictor #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int HISTORY_BITS  = 6,
    parameter int COUNTER_BITS  = 2,
    parameter int THREADS       = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata: thread_id[1:0], branch_address[65:2], taken[66], squashed[67],
    //          saved_history[73:68], saved_index[85:74], record_valid[86]
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [87:0] s_tdata,
    // s_tuser: command[2:0]
    input  wire logic [2:0]  s_tuser,
    // m_tdata: predict_taken[0], history_out[6:1], index_out[18:7]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,
    // m_tuser: record_out_valid[0]
    output logic [0:0]       m_tuser
);
    localparam int IB    = $clog2(TABLE_ENTRIES);
    localparam int DEPTH = 2 ** IB;
    localparam int HB    = HISTORY_BITS;
    localparam int CB    = COUNTER_BITS;
    localparam int AB    = (IB > HB) ? IB - HB : 0;
    localparam int TW    = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int WW    = IB + HB;

    // Input field unpack
    logic [gsbp_pkg::TID_W-1:0]   s_thread_id;
    logic [gsbp_pkg::ADDR_W-1:0]  s_branch_address;
    logic                         s_taken;
    logic                         s_squashed;
    logic [gsbp_pkg::SHIST_W-1:0] s_saved_history;
    logic [gsbp_pkg::SIDX_W-1:0]  s_saved_index;
    logic                         s_record_valid;

    assign s_thread_id      = s_tdata[1:0];
    assign s_branch_address = s_tdata[65:2];
    assign s_taken          = s_tdata[66];
    assign s_squashed       = s_tdata[67];
    assign s_saved_history  = s_tdata[73:68];
    assign s_saved_index    = s_tdata[85:74];
    assign s_record_valid   = s_tdata[86];

    gsbp_pkg::state_t state_reg, state_next;
    logic [IB-1:0]    clr_reg;

    logic [HB-1:0] hist_reg [THREADS];

    // Transaction captured at accept
    logic [2:0]    cmd_reg;
    logic          tid_ok_reg;
    logic [TW-1:0] tid_reg;
    logic          taken_reg;
    logic          squashed_reg;
    logic          rec_reg;
    logic [HB-1:0] sv_hist_reg;
    logic [HB-1:0] old_hist_reg;
    logic [IB-1:0] idx_reg;

    // Output register
    logic        m_valid_reg;
    logic        pred_out_reg;
    logic [5:0]  hist_out_reg;
    logic [11:0] idx_out_reg;
    logic        rec_out_reg;

    logic s_fire;
    logic exec_fire;

    assign s_tready  = (state_reg == gsbp_pkg::ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign exec_fire = (state_reg == gsbp_pkg::ST_EXEC) && (!m_valid_reg || m_tready);

    // Index formation at accept
    logic          s_tid_ok;
    logic [TW-1:0] s_tid;
    logic [HB-1:0] s_old_hist;
    logic [61:0]   word_addr;
    logic [61:0]   pc_mask;
    logic [WW-1:0] idx_wide;
    logic [IB-1:0] lookup_idx;
    logic [IB-1:0] rd_idx;

    assign s_tid_ok   = (32'(s_thread_id) < THREADS);
    assign s_tid      = TW'(s_thread_id);
    assign s_old_hist = s_tid_ok ? hist_reg[s_tid] : '0;
    assign word_addr  = s_branch_address[63:2];
    assign pc_mask    = (62'd1 << AB) - 62'd1;
    assign idx_wide   = (WW'(s_old_hist) << AB) | WW'(word_addr & pc_mask);
    assign lookup_idx = idx_wide[IB-1:0];
    assign rd_idx     = (s_tuser == gsbp_pkg::CMD_LOOKUP) ? lookup_idx : IB'(s_saved_index);

    // Counter table
    logic          ram_we;
    logic [IB-1:0] ram_waddr;
    logic [CB-1:0] ram_wdata;
    logic [CB-1:0] ctr_rd;

    gsbp_ram #(
        .WIDTH (CB),
        .DEPTH (DEPTH)
    ) u_ctr_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (s_fire),
        .raddr (rd_idx),
        .rdata (ctr_rd)
    );

    // Execute stage
    logic          pred;
    logic          do_lookup;
    logic          ctr_we;
    logic [CB-1:0] ctr_new;
    logic          hist_we;
    logic [HB-1:0] hist_next;
    logic [HB-1:0] cur_hist;

    assign pred     = ctr_rd[CB-1];
    assign cur_hist = old_hist_reg;

    always_comb begin
        do_lookup = 1'b0;
        ctr_we    = 1'b0;
        ctr_new   = ctr_rd;
        hist_we   = 1'b0;
        hist_next = cur_hist;
        if (tid_ok_reg) begin
            case (cmd_reg)
                gsbp_pkg::CMD_LOOKUP: begin
                    do_lookup = 1'b1;
                    hist_we   = 1'b1;
                    hist_next = HB'({cur_hist, pred});
                end
                gsbp_pkg::CMD_UPDATE: begin
                    if (rec_reg && squashed_reg) begin
                        hist_we   = 1'b1;
                        hist_next = sv_hist_reg;
                    end else if (rec_reg) begin
                        if (taken_reg && !(&ctr_rd)) begin
                            ctr_we  = 1'b1;
                            ctr_new = ctr_rd + CB'(1);
                        end else if (!taken_reg && (|ctr_rd)) begin
                            ctr_we  = 1'b1;
                            ctr_new = ctr_rd - CB'(1);
                        end
                    end
                end
                gsbp_pkg::CMD_SQUASH: begin
                    if (rec_reg) begin
                        hist_we   = 1'b1;
                        hist_next = sv_hist_reg;
                    end
                end
                gsbp_pkg::CMD_UNCOND: begin
                    hist_we   = 1'b1;
                    hist_next = HB'({cur_hist, 1'b1});
                end
                gsbp_pkg::CMD_BTB_MISS: begin
                    hist_we   = 1'b1;
                    hist_next = HB'({cur_hist, 1'b0});
                end
                default: begin
                    hist_we = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        if (state_reg == gsbp_pkg::ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = exec_fire && ctr_we;
            ram_waddr = idx_reg;
            ram_wdata = ctr_new;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gsbp_pkg::ST_CLEAR: if (&clr_reg) state_next = gsbp_pkg::ST_IDLE;
            gsbp_pkg::ST_IDLE:  if (s_fire) state_next = gsbp_pkg::ST_EXEC;
            gsbp_pkg::ST_EXEC:  if (exec_fire) state_next = gsbp_pkg::ST_IDLE;
            default:            state_next = gsbp_pkg::ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gsbp_pkg::ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int t = 0; t < THREADS; t++) begin
                hist_reg[t] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (state_reg == gsbp_pkg::ST_CLEAR) begin
                clr_reg <= clr_reg + IB'(1);
            end
            if (exec_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (exec_fire && hist_we) begin
                hist_reg[tid_reg] <= hist_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cmd_reg      <= s_tuser;
            tid_ok_reg   <= s_tid_ok;
            tid_reg      <= s_tid;
            taken_reg    <= s_taken;
            squashed_reg <= s_squashed;
            rec_reg      <= s_record_valid;
            sv_hist_reg  <= HB'(s_saved_history);
            old_hist_reg <= s_old_hist;
            idx_reg      <= rd_idx;
        end
        if (exec_fire) begin
            pred_out_reg <= do_lookup && pred;
            hist_out_reg <= do_lookup ? 6'(old_hist_reg) : 6'd0;
            idx_out_reg  <= do_lookup ? 12'(idx_reg) : 12'd0;
            rec_out_reg  <= do_lookup;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {5'd0, idx_out_reg, hist_out_reg, pred_out_reg};
    assign m_tuser[0] = rec_out_reg;

`ifndef SYNTHESIS
    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (state_reg == gsbp_pkg::ST_EXEC))
        else $error("accepted transaction did not enter execute");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == gsbp_pkg::ST_IDLE) |-> !ram_we)
        else $error("counter table written while idle");

    a_lookup_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec_fire && do_lookup) |=> (m_tvalid && m_tuser[0]))
        else $error("lookup did not produce a record");

    a_zero_nonlookup: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 24'd0))
        else $error("non-lookup result carries nonzero data");
`endif

endmodule

`default_nettype wire
